@@ hdl/scds_pkg.sv @@
package scds_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned FIELD_W  = 8;
    localparam int unsigned STEP_W   = 4;
    localparam int unsigned DIVCNT_W = 5;

    localparam logic [DATA_W-1:0]  RESET_CLOCK_HZ = 32'd25000000;
    localparam logic [FIELD_W-1:0] PRESCALE_MIN   = 8'd2;
    localparam logic [FIELD_W-1:0] PRESCALE_MAX   = 8'd254;
    localparam logic [FIELD_W-1:0] PRESCALE_STEP  = 8'd2;
    localparam logic [FIELD_W-1:0] RATE_FIELD_MAX = 8'd255;
    localparam logic [DIVCNT_W-1:0] DIV_LAST_CNT  = 5'd31;

    localparam logic [1:0] OUTCOME_CLAMP = 2'd0;
    localparam logic [1:0] OUTCOME_FIT   = 2'd1;
    localparam logic [1:0] OUTCOME_SLOW  = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_LOAD_TGT  = 4'd1;
    localparam logic [3:0] OP_P_INIT    = 4'd2;
    localparam logic [3:0] OP_D1_LOAD   = 4'd3;
    localparam logic [3:0] OP_D2_LOAD   = 4'd4;
    localparam logic [3:0] OP_DIV_STEP  = 4'd5;
    localparam logic [3:0] OP_P_INC     = 4'd6;
    localparam logic [3:0] OP_OUT_FIT   = 4'd7;
    localparam logic [3:0] OP_OUT_CLAMP = 4'd8;
    localparam logic [3:0] OP_OUT_SLOW  = 4'd9;

    // jump conditions
    localparam logic [2:0] CC_NEVER    = 3'd0;
    localparam logic [2:0] CC_ALWAYS   = 3'd1;
    localparam logic [2:0] CC_IN_REQ   = 3'd2;
    localparam logic [2:0] CC_CLAMP    = 3'd3;
    localparam logic [2:0] CC_DIV_LAST = 3'd4;
    localparam logic [2:0] CC_FIT      = 3'd5;
    localparam logic [2:0] CC_LAST_P   = 3'd6;
    localparam logic [2:0] CC_OUT_FREE = 3'd7;

    // program steps
    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_D1_START  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_D1_RUN    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_D2_START  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_D2_RUN    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_TEST_FIT  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_TEST_LAST = 4'd7;
    localparam logic [STEP_W-1:0] STEP_ADVANCE   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_OUT_FIT   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_OUT_CLAMP = 4'd10;
    localparam logic [STEP_W-1:0] STEP_OUT_SLOW  = 4'd11;

    typedef struct packed {
        logic [3:0]        op;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
        logic              hold;   // stay on this step when cond is false
    } ctrl_word_t;

    function automatic ctrl_word_t ctrl_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        case (step)
            STEP_IDLE:      w = '{OP_LOAD_TGT,  CC_IN_REQ,   STEP_CHECK,     1'b1};
            STEP_CHECK:     w = '{OP_P_INIT,    CC_CLAMP,    STEP_OUT_CLAMP, 1'b0};
            STEP_D1_START:  w = '{OP_D1_LOAD,   CC_NEVER,    STEP_IDLE,      1'b0};
            STEP_D1_RUN:    w = '{OP_DIV_STEP,  CC_DIV_LAST, STEP_D2_START,  1'b1};
            STEP_D2_START:  w = '{OP_D2_LOAD,   CC_NEVER,    STEP_IDLE,      1'b0};
            STEP_D2_RUN:    w = '{OP_DIV_STEP,  CC_DIV_LAST, STEP_TEST_FIT,  1'b1};
            STEP_TEST_FIT:  w = '{OP_NOP,       CC_FIT,      STEP_OUT_FIT,   1'b0};
            STEP_TEST_LAST: w = '{OP_NOP,       CC_LAST_P,   STEP_OUT_SLOW,  1'b0};
            STEP_ADVANCE:   w = '{OP_P_INC,     CC_ALWAYS,   STEP_D1_START,  1'b0};
            STEP_OUT_FIT:   w = '{OP_OUT_FIT,   CC_OUT_FREE, STEP_IDLE,      1'b1};
            STEP_OUT_CLAMP: w = '{OP_OUT_CLAMP, CC_OUT_FREE, STEP_IDLE,      1'b1};
            STEP_OUT_SLOW:  w = '{OP_OUT_SLOW,  CC_OUT_FREE, STEP_IDLE,      1'b1};
            default:        w = '{OP_NOP,       CC_ALWAYS,   STEP_IDLE,      1'b0};
        endcase
        return w;
    endfunction

endpackage

@@ hdl/spi_clock_divider_search_unit.sv @@
// A clamp result passes from idle through the check step and then the clamp output step.
// A search tries each even prescale from 2 upward and falls back to the slowest setting after 254.
// Throughput: a new request is taken once the program is back at idle, even while the
// last result still waits. Each trial runs two 32-step restoring divisions on one divider.
// Reset (rst_n, asynchronous, active low) returns the program to idle, drops
// any pending result and sets clock_hz to 25000000.
module spi_clock_divider_search_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [scds_pkg::DATA_W-1:0]   cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [scds_pkg::DATA_W-1:0]   target_hz,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scds_pkg::FIELD_W-1:0]  prescale,
    output logic [scds_pkg::FIELD_W-1:0]  rate_field,
    output logic [scds_pkg::DATA_W-1:0]   reported_hz,
    output logic [1:0]                    outcome
);
    import scds_pkg::*;

    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DATA_W-1:0]   clock_reg, clock_next;
    logic                out_valid_reg, out_valid_next;

    logic [DATA_W-1:0]   target_reg, target_next;
    logic [FIELD_W-1:0]  p_reg, p_next;
    logic [DATA_W-1:0]   scaled_reg, scaled_next;
    logic [DATA_W-1:0]   div_rem_reg, div_rem_next;
    logic [DATA_W-1:0]   div_quo_reg, div_quo_next;
    logic [DATA_W-1:0]   div_den_reg, div_den_next;
    logic [DIVCNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [FIELD_W-1:0]  prescale_reg, prescale_next;
    logic [FIELD_W-1:0]  rate_field_reg, rate_field_next;
    logic [DATA_W-1:0]   reported_reg, reported_next;
    logic [1:0]          outcome_reg, outcome_next;

    ctrl_word_t          cw;
    logic                cond_true;
    logic                in_accept;
    logic                out_free;
    logic                is_clamp;
    logic                is_fit;
    logic [DATA_W:0]     div_shift;
    logic [DATA_W:0]     div_diff;
    logic                div_ge;

    assign cw        = ctrl_rom(step_reg);
    assign in_stall  = (step_reg != STEP_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_clamp  = (target_reg >= (clock_reg >> 1));
    assign is_fit    = (div_quo_reg[DATA_W-1:FIELD_W] == '0);

    // restoring divider: one quotient bit per step
    assign div_shift = {div_rem_reg, div_quo_reg[DATA_W-1]};
    assign div_diff  = div_shift - {1'b0, div_den_reg};
    assign div_ge    = (div_shift >= {1'b0, div_den_reg});

    always_comb
    begin
        case (cw.cond)
            CC_NEVER:    cond_true = 1'b0;
            CC_ALWAYS:   cond_true = 1'b1;
            CC_IN_REQ:   cond_true = in_valid;
            CC_CLAMP:    cond_true = is_clamp;
            CC_DIV_LAST: cond_true = (div_cnt_reg == DIV_LAST_CNT);
            CC_FIT:      cond_true = is_fit;
            CC_LAST_P:   cond_true = (p_reg == PRESCALE_MAX);
            CC_OUT_FREE: cond_true = out_free;
            default:     cond_true = 1'b0;
        endcase

        if (cond_true)
            step_next = cw.target;
        else if (cw.hold)
            step_next = step_reg;
        else
            step_next = step_reg + 1'b1;
    end

    always_comb
    begin
        clock_next      = cfg_write_en ? cfg_write_data : clock_reg;
        out_valid_next  = out_valid_reg && out_stall;
        target_next     = target_reg;
        p_next          = p_reg;
        scaled_next     = scaled_reg;
        div_rem_next    = div_rem_reg;
        div_quo_next    = div_quo_reg;
        div_den_next    = div_den_reg;
        div_cnt_next    = div_cnt_reg;
        prescale_next   = prescale_reg;
        rate_field_next = rate_field_reg;
        reported_next   = reported_reg;
        outcome_next    = outcome_reg;

        case (cw.op)
            OP_LOAD_TGT:
            begin
                if (in_accept)
                    target_next = target_hz;
            end
            OP_P_INIT:
                p_next = PRESCALE_MIN;
            OP_D1_LOAD:
            begin
                div_quo_next = clock_reg;
                div_den_next = {{(DATA_W-FIELD_W){1'b0}}, p_reg};
                div_rem_next = '0;
                div_cnt_next = '0;
            end
            OP_D2_LOAD:
            begin
                // quotient register already holds clock / prescale
                scaled_next  = div_quo_reg;
                div_den_next = target_reg;
                div_rem_next = '0;
                div_cnt_next = '0;
            end
            OP_DIV_STEP:
            begin
                div_rem_next = div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
                div_quo_next = {div_quo_reg[DATA_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            OP_P_INC:
                p_next = p_reg + PRESCALE_STEP;
            OP_OUT_FIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    prescale_next   = p_reg;
                    rate_field_next = div_quo_reg[FIELD_W-1:0] - 1'b1;
                    reported_next   = target_reg;
                    outcome_next    = OUTCOME_FIT;
                end
            end
            OP_OUT_CLAMP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    prescale_next   = PRESCALE_MIN;
                    rate_field_next = '0;
                    reported_next   = clock_reg >> 1;
                    outcome_next    = OUTCOME_CLAMP;
                end
            end
            OP_OUT_SLOW:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    prescale_next   = PRESCALE_MAX;
                    rate_field_next = RATE_FIELD_MAX;
                    // last trial left clock / 254 in the scaled register
                    reported_next   = scaled_reg >> FIELD_W;
                    outcome_next    = OUTCOME_SLOW;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            clock_reg     <= RESET_CLOCK_HZ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            clock_reg     <= clock_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        p_reg          <= p_next;
        scaled_reg     <= scaled_next;
        div_rem_reg    <= div_rem_next;
        div_quo_reg    <= div_quo_next;
        div_den_reg    <= div_den_next;
        div_cnt_reg    <= div_cnt_next;
        prescale_reg   <= prescale_next;
        rate_field_reg <= rate_field_next;
        reported_reg   <= reported_next;
        outcome_reg    <= outcome_next;
    end

    assign out_valid   = out_valid_reg;
    assign prescale    = prescale_reg;
    assign rate_field  = rate_field_reg;
    assign reported_hz = reported_reg;
    assign outcome     = outcome_reg;

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (step_reg == STEP_CHECK))
        else $error("request accepted but program did not advance to check");

    a_prescale_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_D1_START) |->
            (p_reg[0] == 1'b0) && (p_reg >= PRESCALE_MIN) && (p_reg <= PRESCALE_MAX))
        else $error("trial prescale out of range or odd");

    a_result_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(step_reg) == STEP_OUT_FIT) || ($past(step_reg) == STEP_OUT_CLAMP)
            || ($past(step_reg) == STEP_OUT_SLOW))
        else $error("result raised outside an output step");

    a_fit_even_prescale: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (outcome_reg == OUTCOME_FIT)) |->
            (prescale_reg[0] == 1'b0) && (prescale_reg != '0))
        else $error("fitting result with illegal prescale");

endmodule

@@ bench/testbench.sv @@
module testbench;
    import scds_pkg::*;

    localparam int unsigned LONG_HOLD  = 20000;
    localparam int unsigned RUN_LIMIT  = 150_000_000;
    localparam int unsigned SETTLE     = 100;
    localparam int unsigned PHASE_REQS = 20;

    typedef struct packed {
        logic [FIELD_W-1:0] prescale;
        logic [FIELD_W-1:0] rate_field;
        logic [DATA_W-1:0]  reported_hz;
        logic [1:0]         outcome;
    } divider_setting_t;

    typedef enum logic {ROW_REQ, ROW_CLOCK} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [DATA_W-1:0]  value;
        logic               has_want;
        divider_setting_t   want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [DATA_W-1:0]    cfg_write_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [DATA_W-1:0]    target_hz;
    logic                 out_valid;
    logic                 out_stall;
    logic [FIELD_W-1:0]   prescale;
    logic [FIELD_W-1:0]   rate_field;
    logic [DATA_W-1:0]    reported_hz;
    logic [1:0]           outcome;

    logic [DATA_W-1:0]    periph_clock_hz;
    divider_setting_t     expected_settings[$];
    int unsigned          mismatch_count = 0;
    logic                 idle_on = 1'b1;
    logic                 long_hold_req = 1'b0;

    // clamp at half the clock, else first even prescale whose quotient fits 8 bits
    stim_row_t directed_plan[$] = '{
        '{ROW_REQ,   32'hFFFF_FFFF, 1'b1, '{PRESCALE_MIN, 8'd0, 32'd12500000, OUTCOME_CLAMP}},
        '{ROW_REQ,   32'd12500000,  1'b1, '{PRESCALE_MIN, 8'd0, 32'd12500000, OUTCOME_CLAMP}},
        '{ROW_REQ,   32'd12499999,  1'b1, '{PRESCALE_MIN, 8'd0, 32'd12499999, OUTCOME_FIT}},
        '{ROW_REQ,   32'd1,         1'b1, '{PRESCALE_MAX, RATE_FIELD_MAX, 32'd384, OUTCOME_SLOW}},
        '{ROW_REQ,   32'd0,         1'b1, '{PRESCALE_MAX, RATE_FIELD_MAX, 32'd384, OUTCOME_SLOW}},
        '{ROW_REQ,   32'd50000,     1'b0, '0},
        '{ROW_REQ,   32'd48828,     1'b0, '0},
        '{ROW_REQ,   32'd400,       1'b0, '0},
        '{ROW_REQ,   32'd385,       1'b0, '0},
        '{ROW_REQ,   32'd384,       1'b0, '0},
        '{ROW_CLOCK, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_REQ,   32'hFFFF_FFFF, 1'b1, '{PRESCALE_MIN, 8'd0, 32'h7FFF_FFFF, OUTCOME_CLAMP}},
        '{ROW_REQ,   32'h7FFF_FFFF, 1'b1, '{PRESCALE_MIN, 8'd0, 32'h7FFF_FFFF, OUTCOME_CLAMP}},
        '{ROW_REQ,   32'h7FFF_FFFE, 1'b0, '0},
        '{ROW_REQ,   32'd1,         1'b1, '{PRESCALE_MAX, RATE_FIELD_MAX, 32'd66052, OUTCOME_SLOW}},
        '{ROW_REQ,   32'd0,         1'b1, '{PRESCALE_MAX, RATE_FIELD_MAX, 32'd66052, OUTCOME_SLOW}},
        '{ROW_REQ,   32'h0001_0000, 1'b0, '0},
        '{ROW_CLOCK, 32'd1,         1'b0, '0},
        '{ROW_REQ,   32'd1,         1'b1, '{PRESCALE_MIN, 8'd0, 32'd0, OUTCOME_CLAMP}},
        '{ROW_REQ,   32'd0,         1'b1, '{PRESCALE_MIN, 8'd0, 32'd0, OUTCOME_CLAMP}},
        '{ROW_CLOCK, 32'd0,         1'b0, '0},
        '{ROW_REQ,   32'hFFFF_FFFF, 1'b1, '{PRESCALE_MIN, 8'd0, 32'd0, OUTCOME_CLAMP}},
        '{ROW_CLOCK, 32'd2,         1'b0, '0},
        '{ROW_REQ,   32'd0,         1'b1, '{PRESCALE_MAX, RATE_FIELD_MAX, 32'd0, OUTCOME_SLOW}},
        '{ROW_REQ,   32'd1,         1'b1, '{PRESCALE_MIN, 8'd0, 32'd1, OUTCOME_CLAMP}},
        '{ROW_CLOCK, 32'd25000000,  1'b0, '0},
        '{ROW_REQ,   32'h5555_5555, 1'b0, '0},
        '{ROW_REQ,   32'h2AAA_AAAA, 1'b0, '0}
    };

    spi_clock_divider_search_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .target_hz      (target_hz),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .prescale       (prescale),
        .rate_field     (rate_field),
        .reported_hz    (reported_hz),
        .outcome        (outcome)
    );

    always #10 clk = ~clk;

    function automatic divider_setting_t pick_divider(input logic [DATA_W-1:0] clock_hz,
                                                      input logic [DATA_W-1:0] want_hz);
        logic [DATA_W-1:0] half;
        logic [DATA_W-1:0] scaled;
        logic [DATA_W-1:0] quot;
        half = clock_hz / 2;
        if (want_hz >= half)
            return '{PRESCALE_MIN, 8'd0, half, OUTCOME_CLAMP};
        for (int p = PRESCALE_MIN; p <= PRESCALE_MAX; p += PRESCALE_STEP)
        begin
            scaled = clock_hz / p;
            // a zero divisor reads back as all ones
            quot = (want_hz == 0) ? '1 : scaled / want_hz;
            if (quot <= RATE_FIELD_MAX)
                return '{p[FIELD_W-1:0], quot[FIELD_W-1:0] - 8'd1, want_hz, OUTCOME_FIT};
        end
        return '{PRESCALE_MAX, RATE_FIELD_MAX, (clock_hz / PRESCALE_MAX) / 256, OUTCOME_SLOW};
    endfunction

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_settings.size() != 0);
    endtask

    task automatic set_clock(input logic [DATA_W-1:0] hz);
        drain_results();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= hz;
        @(posedge clk);
        cfg_write_en    <= 1'b0;
        periph_clock_hz  = hz;
    endtask

    task automatic push_target(input logic [DATA_W-1:0] hz, input logic has_want,
                               input divider_setting_t want);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        target_hz <= hz;
        do @(posedge clk); while (in_stall);
        expected_settings.push_back(has_want ? want : pick_divider(periph_clock_hz, hz));
    endtask

    // result side
    initial
    begin
        divider_setting_t got;
        divider_setting_t want;
        int unsigned      pause;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                // hold off long enough that the block backs up into its input
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                pause = idle_on ? $urandom_range(0, 9) : 0;
                if (pause != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (pause) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got = '{prescale, rate_field, reported_hz, outcome};
            if (expected_settings.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected result %0d %0d %0d %0d", $realtime,
                             got.prescale, got.rate_field, got.reported_hz, got.outcome);
                mismatch_count++;
            end
            else
            begin
                want = expected_settings.pop_front();
                if (got !== want)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 $realtime, want.prescale, want.rate_field,
                                 want.reported_hz, want.outcome, got.prescale,
                                 got.rate_field, got.reported_hz, got.outcome);
                    mismatch_count++;
                end
            end
        end
    end

    // request side
    initial
    begin
        logic [DATA_W-1:0] hz;
        logic [DATA_W-1:0] half;
        logic [DATA_W-1:0] want_hz;
        int unsigned       p;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        target_hz      = '0;
        periph_clock_hz = RESET_CLOCK_HZ;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_CLOCK)
                set_clock(directed_plan[i].value);
            else
                push_target(directed_plan[i].value, directed_plan[i].has_want,
                            directed_plan[i].want);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       hz = RESET_CLOCK_HZ;
                1:       hz = $urandom;
                2:       hz = $urandom_range(1000, 100000);
                default: hz = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
            endcase
            set_clock(hz);
            idle_on = (phase != 2);
            if (phase == 1)
                long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                if (phase == 3 && n == PHASE_REQS / 2)
                    drain_results();
                half = periph_clock_hz / 2;
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        want_hz = (half == 0) ? $urandom : half + $urandom_range(0, half);
                    end
                    2: want_hz = $urandom;
                    3: want_hz = $urandom_range(0, 600);
                    default:
                    begin
                        // aim near a quotient boundary, mostly at small prescales
                        p = 2 * $urandom_range(1, ($urandom_range(0, 3) == 0) ? 127 : 16);
                        want_hz = (periph_clock_hz / p) / $urandom_range(1, 300);
                        if ($urandom_range(0, 1) == 1)
                            want_hz = want_hz + 1;
                        if (want_hz == 0)
                            want_hz = 1;
                    end
                endcase
                push_target(want_hz, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
